>>> rtl/range_max_segment_tree_defines.svh
// ----------------------------------------------------------------------------
// range_max_segment_tree_defines
// Assertion macros shared by the segment tree modules. Each expects clk_i and
// rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MAX_SEGMENT_TREE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define RMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg
// Sizes, command format, state encoding and helpers for the max segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int LEAF_COUNT = 1024;               // power of two
  localparam int NODE_COUNT = 2 * LEAF_COUNT;     // node 0 unused, root is 1
  localparam int NODE_W     = $clog2(NODE_COUNT); // node address
  localparam int IDX_W      = NODE_W + 1;         // bound that may reach NODE_COUNT

  localparam int DATA_W  = 32;
  localparam int POS_W   = 10;
  localparam int RANGE_W = 11;

  // command queue, depth a power of two so the pointers wrap by themselves
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_QUERY,
    CMD_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic [IDX_W-1:0]          lo;   // leaf node for a set, left bound node for a query
    logic [IDX_W-1:0]          hi;   // right bound node for a query
    logic signed [DATA_W-1:0]  val;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_FETCH,
    ST_SET_CHECK,
    ST_Q_STEP,
    ST_Q_OUT
  } st_e;

  function automatic logic signed [DATA_W-1:0] smax(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/rmst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> rtl/rmst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_front
// Input side: classifies each item into a tree command, clamps query bounds,
// maps them to node indices and drops sets beyond the leaves.
// ----------------------------------------------------------------------------
module rmst_front import rmst_pkg::*; (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic signed [DATA_W-1:0]  value_i,
  input  logic [RANGE_W-1:0]        range_left_i,
  input  logic [RANGE_W-1:0]        range_right_i,
  input  logic                      q_ready_i,
  input  logic                      init_done_i,
  output logic                      q_push_o,
  output cmd_t                      q_cmd_o
);

  localparam logic [RANGE_W-1:0] LeafLim = RANGE_W'(LEAF_COUNT);

  logic [RANGE_W-1:0] left_c;
  logic [RANGE_W-1:0] right_c;
  logic               drop;

  always_comb begin
    left_c  = (range_left_i  > LeafLim) ? LeafLim : range_left_i;
    right_c = (range_right_i > LeafLim) ? LeafLim : range_right_i;

    q_cmd_o.val = value_i;
    drop        = 1'b0;
    if (op_e'(operation_i) == OP_SET) begin
      q_cmd_o.kind = CMD_SET;
      q_cmd_o.lo   = IDX_W'(LEAF_COUNT) + IDX_W'(position_i);
      q_cmd_o.hi   = '0;
      drop         = (32'(position_i) >= 32'(LEAF_COUNT));
    end else begin
      // empty span answers zero without touching the tree
      q_cmd_o.kind = (left_c >= right_c) ? CMD_ZERO : CMD_QUERY;
      q_cmd_o.lo   = IDX_W'(left_c)  + IDX_W'(LEAF_COUNT);
      q_cmd_o.hi   = IDX_W'(right_c) + IDX_W'(LEAF_COUNT);
    end
  end

  assign in_ready_o = q_ready_i & init_done_i;
  assign q_push_o   = in_valid_i & in_ready_o & ~drop;

endmodule

>>> rtl/rmst_cmd_fifo.sv
`timescale 1ns / 1ps
`include "range_max_segment_tree_defines.svh"
// ----------------------------------------------------------------------------
// rmst_cmd_fifo
// Short command queue between the front and the tree engine.
// ----------------------------------------------------------------------------
module rmst_cmd_fifo import rmst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, wptr_d;
  logic [CMDQ_AW-1:0] rptr_q, rptr_d;
  logic [CMDQ_CW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != CMDQ_CW'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  `RMST_ASSERT(a_fifo_no_overflow, (cnt_q == CMDQ_CW'(CMDQ_DEPTH)) |-> !push_i, "push into full queue")
  `RMST_ASSERT_NEXT(a_fifo_fill, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "fill count lost a push")

endmodule

>>> rtl/rmst_back.sv
`timescale 1ns / 1ps
`include "range_max_segment_tree_defines.svh"
// ----------------------------------------------------------------------------
// rmst_back
// Tree engine: clears the node memory after reset, then walks the tree for
// each set or non-empty query, one level per step, and holds query results for the output.
// ----------------------------------------------------------------------------
module rmst_back import rmst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  cmd_t                     q_cmd_i,
  output logic                     q_pop_o,
  output logic                     init_done_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] maximum_o
);

  st_e                       st_q, st_d;
  logic [NODE_W-1:0]         clr_q, clr_d;
  logic [NODE_W-1:0]         node_q, node_d;
  logic signed [DATA_W-1:0]  val_q, val_d;
  logic signed [DATA_W-1:0]  old_q, old_d;
  logic                      up_q, up_d;
  logic [IDX_W-1:0]          l_q, l_d;
  logic [IDX_W-1:0]          r_q, r_d;
  logic                      va_q, va_d;
  logic                      vb_q, vb_d;
  logic signed [DATA_W-1:0]  acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0]  max_q, max_d;

  logic                      ram_we;
  logic [NODE_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]         ram_wdata;
  logic [NODE_W-1:0]         ram_raddr_a;
  logic [NODE_W-1:0]         ram_raddr_b;
  logic [DATA_W-1:0]         ram_rdata_a;
  logic [DATA_W-1:0]         ram_rdata_b;

  logic                      out_free;
  logic                      span_open;
  logic [IDX_W-1:0]          l_nx;
  logic [IDX_W-1:0]          r_nx;
  logic signed [DATA_W-1:0]  fold_a;
  logic signed [DATA_W-1:0]  fold_b;

  rmst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NODE_COUNT)
  ) u_nodes (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(ram_rdata_a),
    .rdata_b_o(ram_rdata_b)
  );

  assign out_free  = ~out_valid_q | out_ready_i;
  assign span_open = (l_q < r_q);
  // left bound steps past an odd node, an odd right bound steps back by one
  assign l_nx      = l_q + IDX_W'(l_q[0]);
  assign r_nx      = r_q - IDX_W'(r_q[0]);
  // fold in the nodes read on the previous step
  assign fold_a    = va_q ? smax(acc_q, $signed(ram_rdata_a)) : acc_q;
  assign fold_b    = vb_q ? smax(fold_a, $signed(ram_rdata_b)) : fold_a;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLEAR: begin
        if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.kind)
            CMD_SET:   st_d = ST_SET_FETCH;
            CMD_QUERY: st_d = ST_Q_STEP;
            default:   st_d = ST_Q_OUT;
          endcase
        end
      end
      ST_SET_FETCH: st_d = ST_SET_CHECK;
      ST_SET_CHECK: begin
        if ((old_q == val_q) || (node_q == NODE_W'(1))) begin
          st_d = ST_IDLE;
        end else begin
          st_d = ST_SET_FETCH;
        end
      end
      ST_Q_STEP: begin
        if (!span_open) begin
          st_d = ST_Q_OUT;
        end
      end
      ST_Q_OUT: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    node_d      = node_q;
    val_d       = val_q;
    old_d       = old_q;
    up_d        = up_q;
    l_d         = l_q;
    r_d         = r_q;
    va_d        = va_q;
    vb_d        = vb_q;
    acc_d       = acc_q;
    max_d       = max_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = val_q;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    case (st_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o     = 1'b1;
          node_d      = q_cmd_i.lo[NODE_W-1:0];
          val_d       = q_cmd_i.val;
          up_d        = 1'b0;
          l_d         = q_cmd_i.lo;
          r_d         = q_cmd_i.hi;
          acc_d       = '0;
          va_d        = 1'b0;
          vb_d        = 1'b0;
          ram_raddr_a = q_cmd_i.lo[NODE_W-1:0];
        end
      end
      ST_SET_FETCH: begin
        old_d = $signed(ram_rdata_a);
        if (up_q) begin
          val_d = smax(val_q, $signed(ram_rdata_b));
        end
      end
      ST_SET_CHECK: begin
        // stop once the node already holds the value
        if (old_q != val_q) begin
          ram_we      = 1'b1;
          ram_raddr_a = node_q >> 1;
          ram_raddr_b = node_q ^ NODE_W'(1);
          node_d      = node_q >> 1;
          up_d        = 1'b1;
        end
      end
      ST_Q_STEP: begin
        acc_d       = fold_b;
        ram_raddr_a = l_q[NODE_W-1:0];
        ram_raddr_b = r_nx[NODE_W-1:0];
        if (span_open) begin
          l_d  = l_nx >> 1;
          r_d  = r_nx >> 1;
          va_d = l_q[0];
          vb_d = r_q[0];
        end else begin
          va_d = 1'b0;
          vb_d = 1'b0;
        end
      end
      ST_Q_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          max_d       = acc_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      up_q        <= 1'b0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      up_q        <= up_d;
      va_q        <= va_d;
      vb_q        <= vb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    val_q  <= val_d;
    old_q  <= old_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    max_q  <= max_d;
  end

  assign init_done_o = (st_q != ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign maximum_o   = max_q;

  `RMST_ASSERT(a_query_no_write, ((st_q == ST_Q_STEP) || (st_q == ST_Q_OUT)) |-> !ram_we, "tree written during a query")
  `RMST_ASSERT(a_result_nonneg, out_valid_q |-> !max_q[DATA_W-1], "query result below zero")
  `RMST_ASSERT(a_no_node_zero, (ram_we && (st_q != ST_CLEAR)) |-> (ram_waddr != '0), "write to unused node zero")

endmodule

>>> rtl/range_max_segment_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Max segment tree over 1024 signed leaves: point set and half-open range max.
// ----------------------------------------------------------------------------
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------
//   in      | in_valid_i / in_ready_o   | operation, position, value,
//           |                           | range_left, range_right
//   out     | out_valid_o / out_ready_i | maximum (one per query)
//
// A set walks up the tree from its leaf, ending early when a node already
// holds its new value. A query walks up one level per step while its span
// stays open; an empty span answers zero without reading the tree. Each set
// level takes a fetch and a check state, as node memory reads are registered.
// After reset a clearing pass zeroes all 2048 nodes; in_ready_o stays low
// meanwhile. A two-entry command queue keeps input flowing, until it fills,
// while the engine works or a result waits on out_ready_i.
module range_max_segment_tree import rmst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [RANGE_W-1:0]       range_left_i,
  input  logic [RANGE_W-1:0]       range_right_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] maximum_o
);

  logic q_ready;
  logic q_push;
  logic q_pop;
  logic q_valid;
  logic init_done;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  rmst_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .range_left_i (range_left_i),
    .range_right_i(range_right_i),
    .q_ready_i    (q_ready),
    .init_done_i  (init_done),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  rmst_cmd_fifo u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (pop_cmd)
  );

  rmst_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .init_done_o(init_done),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .maximum_o  (maximum_o)
  );

endmodule
